// ===== src/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg: shared definitions for the cache tag lookup unit
// Field widths, codes for outcomes, policies and register indexes, and the
// default geometry handed to the top level.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // Geometry defaults for the top-level parameters.
  localparam int MAX_SETS_DEF = 256;
  localparam int MAX_WAYS_DEF = 8;

  // Address handling. Addresses are masked to ADDR_BITS before use.
  localparam int ADDR_W    = 32;
  localparam int ADDR_BITS = 32;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  // A set index taken from the address is at most this wide before reduction.
  localparam int SET_RAW_W = 15;

  // Random replacement LFSR.
  localparam int                LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

  // Dividend width of the shared remainder unit.
  localparam int DIV_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 2'd3;

  // Replacement policy codes.
  typedef logic [1:0] policy_t;
  localparam policy_t POL_LRU  = 2'd0;
  localparam policy_t POL_MRU  = 2'd1;
  localparam policy_t POL_RAND = 2'd2;

  // Result outcome codes.
  typedef logic [1:0] outcome_t;
  localparam outcome_t OUT_HIT   = 2'd0;
  localparam outcome_t OUT_FREE  = 2'd1;
  localparam outcome_t OUT_EVICT = 2'd2;

endpackage

// ===== src/sacl_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and holds its
// value until the next read.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sacl_rem.sv =====
// ----------------------------------------------------------------------------
// sacl_rem: iterative remainder unit
// Restoring remainder, one dividend bit per cycle. The result is valid in the
// cycle that done is high and holds until the next start.
// ----------------------------------------------------------------------------
module sacl_rem
  import sacl_pkg::*;
#(
  parameter int DVW = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVW-1:0]   divisor,
  output logic             done,
  output logic [DVW-1:0]   remainder
);

  localparam int CW = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DVW-1:0]   d_r, d_nxt;
  logic [DVW-1:0]   r_r, r_nxt;
  logic [DVW:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    r_nxt    = r_r;
    trial    = {r_r, q_r[DIV_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      d_nxt    = divisor;
      r_nxt    = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = DVW'(trial - {1'b0, d_r});
      end else begin
        r_nxt = trial[DVW-1:0];
      end
      q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    d_r <= d_nxt;
    r_r <= r_nxt;
  end

  assign done      = done_r;
  assign remainder = r_r;

endmodule

// ===== src/set_assoc_cache_tag_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_unit: set-associative tag lookup with LRU, MRU
// and random replacement
// Each item is one address. The unit looks the tag up in its set, keeps the
// ways of every set in recency order (most recent at way 0; a random eviction
// writes in place) and returns if the access hit, filled a free way or evicted.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_stall   in_address
//   out      output     out_valid/out_stall out_outcome, out_evicted_address
//   cfg      input      cfg_we              cfg_index, cfg_wdata
//
// After reset the unit clears the valid memory, one set per cycle; in_stall
// stays high meanwhile but configuration writes are taken. An item is then
// accepted, its set index is reduced in the remainder unit when MAX_SETS is
// not a power of two, the valid bits of the set are read, the line memory is
// read way by way until a hit, a free way or the last way in use, the older
// lines are written back one way down and the front way is written, and the
// result is handed over. A random eviction replaces the shift with a pass
// through the remainder unit that picks the victim way. A waiting result
// sits in the output register; the next item is taken once the current one
// has passed into it.
//
module set_assoc_cache_tag_lookup_unit
  import sacl_pkg::*;
#(
  parameter int MAX_SETS = MAX_SETS_DEF,
  parameter int MAX_WAYS = MAX_WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input item channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_W-1:0]     in_address,
  // Result item channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_outcome,
  output logic [ADDR_W-1:0]     out_evicted_address,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Widths that follow from the geometry.
  localparam int LINES = MAX_SETS * MAX_WAYS;
  localparam int SAW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;  // set index
  localparam int WIW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;  // way index
  localparam int WCW   = $clog2(MAX_WAYS + 1);                   // way count
  localparam int LAW   = (LINES > 1) ? $clog2(LINES) : 1;        // line address
  localparam int DVW   = ($clog2(MAX_SETS + 1) > WCW) ? $clog2(MAX_SETS + 1) : WCW;

  localparam bit             SET_POW2 = ((MAX_SETS & (MAX_SETS - 1)) == 0);
  localparam logic [SAW-1:0] SET_MASK = SAW'(MAX_SETS - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SETMOD = 3'd2;
  localparam logic [2:0] S_VREAD  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_WB     = 3'd5;
  localparam logic [2:0] S_RAND   = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  function automatic logic [LAW-1:0] line_addr(input logic [SAW-1:0] set_idx,
                                               input logic [WIW-1:0] way);
    return LAW'(set_idx) * LAW'(MAX_WAYS) + LAW'(way);
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

  // Configuration registers.
  logic [3:0] set_bits_r;
  logic [4:0] offset_bits_r;
  logic [3:0] ways_in_use_r;
  policy_t    policy_r;

  // Sequencer and item state.
  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] tag_mask_r, tag_mask_nxt;
  logic [SAW-1:0]    set_r, set_nxt;
  logic [WCW-1:0]    ways_r, ways_nxt;
  logic [WIW-1:0]    last_r, last_nxt;
  logic [WIW-1:0]    scan_r, scan_nxt;
  logic [WIW-1:0]    wb_r, wb_nxt;
  logic [WIW-1:0]    sh_r, sh_nxt;
  logic [ADDR_W-1:0] front_r, front_nxt;
  logic [ADDR_W-1:0] evict_r, evict_nxt;
  outcome_t          outcome_r, outcome_nxt;
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic [SAW-1:0]    clr_r, clr_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  outcome_t          out_outcome_r, out_outcome_nxt;
  logic [ADDR_W-1:0] out_evicted_r, out_evicted_nxt;

  // Lines read during the scan, kept for the shift and the eviction that follow.
  logic [ADDR_W-1:0] line_buf_r [MAX_WAYS];
  logic              buf_we;
  logic [WIW-1:0]    buf_widx;
  logic [WIW-1:0]    buf_ridx;
  logic [ADDR_W-1:0] buf_rdata;

  // Memory ports.
  logic              s_we, s_re;
  logic [LAW-1:0]    s_waddr, s_raddr;
  logic [ADDR_W-1:0] s_wdata, s_rdata;
  logic              v_we, v_re;
  logic [SAW-1:0]    v_waddr, v_raddr;
  logic [MAX_WAYS-1:0] v_wdata, v_rdata;

  // Remainder unit.
  logic             rem_start;
  logic [DIV_W-1:0] rem_dividend;
  logic [DVW-1:0]   rem_divisor;
  logic             rem_done;
  logic [DVW-1:0]   rem_q;

  // Decode of the incoming address.
  logic [ADDR_W-1:0]    a_in;
  logic [ADDR_W-1:0]    a_shifted;
  logic [SET_RAW_W-1:0] set_field_mask;
  logic [SET_RAW_W-1:0] raw_set;
  logic [5:0]           tag_shift;
  logic [ADDR_W-1:0]    tag_mask_in;
  logic [WCW-1:0]       ways_eff;
  logic [LFSR_W-1:0]    lfsr_adv;
  logic [MAX_WAYS-1:0]  fill_mask;
  logic                 line_match;
  logic                 can_load;

  assign a_in           = in_address & ADDR_MASK;
  assign a_shifted      = a_in >> offset_bits_r;
  assign set_field_mask = SET_RAW_W'((16'd1 << set_bits_r) - 16'd1);
  assign raw_set        = a_shifted[SET_RAW_W-1:0] & set_field_mask;
  assign tag_shift      = 6'(set_bits_r) + 6'(offset_bits_r);
  // The tag shift can reach 46 bits; at 32 or more nothing of the tag is left.
  assign tag_mask_in    = (tag_shift >= 6'd32) ? '0 : ({ADDR_W{1'b1}} << tag_shift);
  assign lfsr_adv       = lfsr_step(lfsr_r);

  // A way count of zero behaves as one; counts above the array size are clipped.
  always_comb begin
    if (ways_in_use_r == 4'd0) begin
      ways_eff = WCW'(1);
    end else if ({1'b0, ways_in_use_r} > 5'(MAX_WAYS)) begin
      ways_eff = WCW'(MAX_WAYS);
    end else begin
      ways_eff = WCW'(ways_in_use_r);
    end
  end

  // Ways 0 to sh_r are marked valid when the write-back finishes.
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      fill_mask[j] = (WIW'(j) <= sh_r);
    end
  end

  // Stored lines are compared by recomputing their tag with the current layout.
  assign line_match = (((s_rdata ^ addr_r) & tag_mask_r) == '0);
  assign can_load   = !out_valid_r || !out_stall;
  assign buf_rdata  = line_buf_r[buf_ridx];

  always_comb begin
    state_nxt       = state_r;
    addr_nxt        = addr_r;
    tag_mask_nxt    = tag_mask_r;
    set_nxt         = set_r;
    ways_nxt        = ways_r;
    last_nxt        = last_r;
    scan_nxt        = scan_r;
    wb_nxt          = wb_r;
    sh_nxt          = sh_r;
    front_nxt       = front_r;
    evict_nxt       = evict_r;
    outcome_nxt     = outcome_r;
    lfsr_nxt        = lfsr_r;
    clr_nxt         = clr_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_outcome_nxt = out_outcome_r;
    out_evicted_nxt = out_evicted_r;

    buf_we    = 1'b0;
    buf_widx  = scan_r;
    buf_ridx  = WIW'(wb_r - 1'b1);

    s_we      = 1'b0;
    s_waddr   = line_addr(set_r, wb_r);
    s_wdata   = front_r;
    s_re      = 1'b0;
    s_raddr   = line_addr(set_r, WIW'(scan_r + 1'b1));
    v_we      = 1'b0;
    v_waddr   = set_r;
    v_wdata   = v_rdata | fill_mask;
    v_re      = 1'b0;
    v_raddr   = set_r;

    rem_start    = 1'b0;
    rem_dividend = DIV_W'(raw_set);
    rem_divisor  = DVW'(MAX_SETS);

    case (state_r)
      S_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr_r;
        v_wdata = '0;
        if (clr_r == SAW'(MAX_SETS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          addr_nxt     = a_in;
          tag_mask_nxt = tag_mask_in;
          ways_nxt     = ways_eff;
          last_nxt     = WIW'(ways_eff - 1'b1);
          if (SET_POW2) begin
            set_nxt   = raw_set[SAW-1:0] & SET_MASK;
            state_nxt = S_VREAD;
          end else begin
            rem_start = 1'b1;
            state_nxt = S_SETMOD;
          end
        end
      end

      S_SETMOD: begin
        if (rem_done) begin
          set_nxt   = rem_q[SAW-1:0];
          state_nxt = S_VREAD;
        end
      end

      S_VREAD: begin
        v_re      = 1'b1;
        s_re      = 1'b1;
        s_raddr   = line_addr(set_r, '0);
        scan_nxt  = '0;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        if (!v_rdata[scan_r]) begin
          // The first free way ends the search.
          outcome_nxt = OUT_FREE;
          evict_nxt   = '0;
          front_nxt   = addr_r;
          sh_nxt      = scan_r;
          wb_nxt      = scan_r;
          state_nxt   = S_WB;
        end else if (line_match) begin
          // Hit: the line keeps its stored address and moves to the front.
          outcome_nxt = OUT_HIT;
          evict_nxt   = '0;
          front_nxt   = s_rdata;
          sh_nxt      = scan_r;
          wb_nxt      = scan_r;
          state_nxt   = S_WB;
        end else begin
          buf_we = 1'b1;
          if (scan_r == last_r) begin
            outcome_nxt = OUT_EVICT;
            front_nxt   = addr_r;
            case (policy_r)
              POL_MRU: begin
                evict_nxt = (scan_r == '0) ? s_rdata : line_buf_r[0];
                sh_nxt    = '0;
                wb_nxt    = '0;
                state_nxt = S_WB;
              end
              POL_RAND: begin
                lfsr_nxt     = lfsr_adv;
                rem_start    = 1'b1;
                rem_dividend = DIV_W'(lfsr_adv);
                rem_divisor  = DVW'(ways_r);
                state_nxt    = S_RAND;
              end
              default: begin
                // LRU, and the unused code that behaves as LRU.
                evict_nxt = s_rdata;
                sh_nxt    = scan_r;
                wb_nxt    = scan_r;
                state_nxt = S_WB;
              end
            endcase
          end else begin
            s_re     = 1'b1;
            scan_nxt = scan_r + 1'b1;
          end
        end
      end

      S_WB: begin
        // Shift the older lines down one way, then write the front way.
        s_we = 1'b1;
        if (wb_r == '0) begin
          s_wdata   = front_r;
          v_we      = 1'b1;
          state_nxt = S_RESP;
        end else begin
          s_wdata = buf_rdata;
          wb_nxt  = wb_r - 1'b1;
        end
      end

      S_RAND: begin
        buf_ridx = rem_q[WIW-1:0];
        if (rem_done) begin
          evict_nxt = buf_rdata;
          s_we      = 1'b1;
          s_waddr   = line_addr(set_r, rem_q[WIW-1:0]);
          s_wdata   = addr_r;
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (can_load) begin
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = outcome_r;
          out_evicted_nxt = evict_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      lfsr_r        <= LFSR_SEED;
      out_valid_r   <= 1'b0;
      set_bits_r    <= 4'd0;
      offset_bits_r <= 5'd0;
      ways_in_use_r <= 4'd1;
      policy_r      <= POL_LRU;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_BITS:    set_bits_r    <= cfg_wdata[3:0];
          CFG_OFFSET_BITS: offset_bits_r <= cfg_wdata[4:0];
          CFG_WAYS_IN_USE: ways_in_use_r <= cfg_wdata[3:0];
          CFG_POLICY:      policy_r      <= cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r        <= addr_nxt;
    tag_mask_r    <= tag_mask_nxt;
    set_r         <= set_nxt;
    ways_r        <= ways_nxt;
    last_r        <= last_nxt;
    scan_r        <= scan_nxt;
    wb_r          <= wb_nxt;
    sh_r          <= sh_nxt;
    front_r       <= front_nxt;
    evict_r       <= evict_nxt;
    outcome_r     <= outcome_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_evicted_r <= out_evicted_nxt;
    if (buf_we) begin
      line_buf_r[buf_widx] <= s_rdata;
    end
  end

  // Stored address of every line, one entry per way of every set.
  sacl_ram #(
    .DEPTH (LINES),
    .WIDTH (ADDR_W),
    .AW    (LAW)
  ) u_line_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Valid bits, one row of MAX_WAYS bits per set.
  sacl_ram #(
    .DEPTH (MAX_SETS),
    .WIDTH (MAX_WAYS),
    .AW    (SAW)
  ) u_valid_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .re    (v_re),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // Shared remainder unit: set index reduction and random victim selection.
  sacl_rem #(
    .DVW (DVW)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (rem_dividend),
    .divisor   (rem_divisor),
    .done      (rem_done),
    .remainder (rem_q)
  );

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_outcome         = out_outcome_r;
  assign out_evicted_address = out_evicted_r;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the set-associative tag lookup unit
// Drives addresses through the unit under several register settings and
// compares every result item with a typed-in result or with a behavioural copy
// of the tag store, its recency order and the replacement LFSR in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import sacl_pkg::*;

  localparam int LINES         = MAX_SETS_DEF * MAX_WAYS_DEF;
  // Time watched for stray results once every expected result has arrived.
  localparam int DRAIN_CYCLES  = 100;
  localparam int DIRECTED_ROWS = 37;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 45;
  localparam int TAG_POOL      = 10;
  localparam int SET_POOL      = 3;

  // One result item as the unit reports it.
  typedef struct packed {
    outcome_t          outcome;
    logic [ADDR_W-1:0] evicted;
  } lookup_t;

  // One row of the directed stimulus: either a register write or an access.
  // Accesses whose result is obvious carry it typed in; the rest are
  // checked against the behavioural store.
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    value;
    logic                 typed;
    outcome_t             outcome;
    logic [ADDR_W-1:0]    evicted;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [ADDR_W-1:0]     in_address;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_outcome;
  logic [ADDR_W-1:0]     out_evicted_address;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Bench copy of the register file, as the unit should hold it.
  logic [3:0]  cfg_set_bits    = 4'd0;
  logic [4:0]  cfg_offset_bits = 5'd0;
  logic [3:0]  cfg_ways        = 4'd1;
  policy_t     cfg_policy      = POL_LRU;

  // Bench copy of the line store, its valid bits and the replacement LFSR.
  logic [ADDR_W-1:0] line_copy [LINES];
  bit                line_held [LINES];
  logic [LFSR_W-1:0] lfsr_copy = LFSR_SEED;

  lookup_t   expected_results [$];
  lookup_t   oldest;
  int        mismatches     = 0;
  int        send_idle_pct  = 37;
  int        recv_stall_pct = 47;
  plan_row_t directed_plan [DIRECTED_ROWS];

  set_assoc_cache_tag_lookup_unit #(
    .MAX_SETS (MAX_SETS_DEF),
    .MAX_WAYS (MAX_WAYS_DEF)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_address          (in_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_outcome         (out_outcome),
    .out_evicted_address (out_evicted_address),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioural lookup
  // ---------------------------------------------------------------------------

  // Moves ways 0 .. upto-1 of a set one place towards the back, leaving way 0
  // free for the line that has just been used.
  function automatic void move_down(input int base, input int upto);
    int i;
    for (i = upto; i > 0; i--) begin
      line_copy[base + i] = line_copy[base + i - 1];
      line_held[base + i] = line_held[base + i - 1];
    end
  endfunction

  // Works out the result of one access and updates the bench copy of the
  // store in the same way the unit must.
  function automatic lookup_t predict_lookup(input logic [ADDR_W-1:0] addr);
    logic [63:0]       a;
    logic [63:0]       tag;
    logic [63:0]       set_raw;
    logic [ADDR_W-1:0] keep;
    int                sh;
    int                w;
    int                base;
    int                victim;
    int                i;
    lookup_t           r;
    a       = {32'd0, addr & ADDR_MASK};
    sh      = int'(cfg_set_bits) + int'(cfg_offset_bits);
    tag     = a >> sh;
    set_raw = (a >> cfg_offset_bits) & ((64'd1 << cfg_set_bits) - 64'd1);
    // A way count of zero acts as one; anything above the hardware acts as
    // the full set.
    if (cfg_ways == 4'd0) w = 1;
    else if (int'(cfg_ways) > MAX_WAYS_DEF) w = MAX_WAYS_DEF;
    else w = int'(cfg_ways);
    base      = int'(set_raw % MAX_SETS_DEF) * MAX_WAYS_DEF;
    r.evicted = '0;
    for (i = 0; i < w; i++) begin
      // Stored lines are compared by their tag under the current registers.
      if (line_held[base + i] && (({32'd0, line_copy[base + i]} >> sh) == tag)) begin
        keep = line_copy[base + i];
        move_down(base, i);
        line_copy[base] = keep;
        line_held[base] = 1'b1;
        r.outcome       = OUT_HIT;
        return r;
      end
      if (!line_held[base + i]) begin
        move_down(base, i);
        line_copy[base] = a[ADDR_W-1:0];
        line_held[base] = 1'b1;
        r.outcome       = OUT_FREE;
        return r;
      end
    end
    r.outcome = OUT_EVICT;
    case (cfg_policy)
      POL_MRU: begin
        r.evicted       = line_copy[base];
        line_copy[base] = a[ADDR_W-1:0];
        line_held[base] = 1'b1;
      end
      POL_RAND: begin
        // Galois LFSR steps once per random eviction, then picks the way.
        if (lfsr_copy[0]) lfsr_copy = (lfsr_copy >> 1) ^ LFSR_TAPS;
        else lfsr_copy = lfsr_copy >> 1;
        victim                   = int'(lfsr_copy) % w;
        r.evicted                = line_copy[base + victim];
        line_copy[base + victim] = a[ADDR_W-1:0];
        line_held[base + victim] = 1'b1;
      end
      default: begin
        // LRU, and the unused policy code, drop the last way in use.
        r.evicted = line_copy[base + w - 1];
        move_down(base, w - 1);
        line_copy[base] = a[ADDR_W-1:0];
        line_held[base] = 1'b1;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Table helpers
  // ---------------------------------------------------------------------------

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] index,
                                        input logic [CFG_DATA_W-1:0] data);
    return '{1'b1, index, ADDR_W'(data), 1'b0, OUT_HIT, '0};
  endfunction

  function automatic plan_row_t access_row(input logic [ADDR_W-1:0] addr);
    return '{1'b0, CFG_SET_BITS, addr, 1'b0, OUT_HIT, '0};
  endfunction

  function automatic plan_row_t known_row(input logic [ADDR_W-1:0] addr,
                                          input outcome_t outcome,
                                          input logic [ADDR_W-1:0] evicted);
    return '{1'b0, CFG_SET_BITS, addr, 1'b1, outcome, evicted};
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks. Every input changes at a falling edge only.
  // ---------------------------------------------------------------------------

  // Writes one register and mirrors it in the bench; callers first wait until no item is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_SET_BITS:    cfg_set_bits    = data[3:0];
      CFG_OFFSET_BITS: cfg_offset_bits = data[4:0];
      CFG_WAYS_IN_USE: cfg_ways        = data[3:0];
      CFG_POLICY:      cfg_policy      = policy_t'(data[1:0]);
      default: ;
    endcase
  endtask

  // Lowers valid and holds off until every outstanding result has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Offers one address, with random idle cycles in front of it, and records
  // the expected result once the unit has taken the item.
  task automatic send_access(input logic [ADDR_W-1:0] addr, input bit typed,
                             input lookup_t known);
    lookup_t want;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_lookup(addr);
    expected_results.push_back(typed ? known : want);
  endtask

  // The receiver stalls at random; the rate follows the current idling mode.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checking: every accepted result is matched against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: outcome %0d evicted %h",
                 $time, out_outcome, out_evicted_address);
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        if (out_outcome !== oldest.outcome) begin
          $display("%0t: outcome mismatch: expected %0d actual %0d",
                   $time, oldest.outcome, out_outcome);
          mismatches++;
        end
        if (out_evicted_address !== oldest.evicted) begin
          $display("%0t: evicted address mismatch: expected %h actual %h",
                   $time, oldest.evicted, out_evicted_address);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [ADDR_W-1:0]     tag_pool [TAG_POOL];
    logic [ADDR_W-1:0]     set_pool [SET_POOL];
    logic [63:0]           composed;
    logic [ADDR_W-1:0]     addr;
    logic [CFG_DATA_W-1:0] sb;
    logic [CFG_DATA_W-1:0] ob;
    logic [CFG_DATA_W-1:0] wy;
    logic [CFG_DATA_W-1:0] pl;
    int                    k;
    int                    phase;
    int                    n;
    in_valid   = 1'b0;
    in_address = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    rst_n      = 1'b0;
    for (k = 0; k < LINES; k++) begin
      line_copy[k] = '0;
      line_held[k] = 1'b0;
    end

    // Directed part. The first block restates the reset values and checks a
    // free fill, an eviction of an all-zero address and a hit on all ones in
    // a single direct-mapped set. Then MRU with two ways, including a hit
    // that differs only in the byte offset, so the stored address must be
    // the original one when it is later evicted. Then random replacement with
    // the set field and way count set beyond the hardware, every address
    // falling into the same set once the index wraps. Then a way count of
    // zero with the unused policy code, which must act as direct-mapped LRU.
    // Last, an offset so wide that only the top address bit is left as the tag.
    directed_plan = '{
      cfg_row(CFG_SET_BITS, 5'd0),
      cfg_row(CFG_OFFSET_BITS, 5'd0),
      cfg_row(CFG_WAYS_IN_USE, 5'd1),
      cfg_row(CFG_POLICY, CFG_DATA_W'(POL_LRU)),
      known_row(32'h0000_0000, OUT_FREE, 32'h0000_0000),
      known_row(32'hFFFF_FFFF, OUT_EVICT, 32'h0000_0000),
      known_row(32'hFFFF_FFFF, OUT_HIT, 32'h0000_0000),
      cfg_row(CFG_SET_BITS, 5'd1),
      cfg_row(CFG_OFFSET_BITS, 5'd4),
      cfg_row(CFG_WAYS_IN_USE, 5'd2),
      cfg_row(CFG_POLICY, CFG_DATA_W'(POL_MRU)),
      access_row(32'h0000_0100),
      access_row(32'h0000_0200),
      access_row(32'h0000_010F),
      access_row(32'h0000_0300),
      cfg_row(CFG_SET_BITS, 5'd15),
      cfg_row(CFG_OFFSET_BITS, 5'd0),
      cfg_row(CFG_WAYS_IN_USE, 5'd15),
      cfg_row(CFG_POLICY, CFG_DATA_W'(POL_RAND)),
      access_row(32'h0001_7FAB),
      access_row(32'h0002_00AB),
      access_row(32'h0003_7FAB),
      access_row(32'h0004_00AB),
      access_row(32'h0005_7FAB),
      access_row(32'h0006_00AB),
      access_row(32'h0007_7FAB),
      access_row(32'h0008_00AB),
      access_row(32'h0009_7FAB),
      cfg_row(CFG_WAYS_IN_USE, 5'd0),
      cfg_row(CFG_POLICY, 5'd3),
      cfg_row(CFG_SET_BITS, 5'd8),
      cfg_row(CFG_OFFSET_BITS, 5'd16),
      known_row(32'hAB12_3456, OUT_FREE, 32'h0000_0000),
      known_row(32'hCD12_5678, OUT_EVICT, 32'hAB12_3456),
      cfg_row(CFG_OFFSET_BITS, 5'd31),
      cfg_row(CFG_SET_BITS, 5'd0),
      access_row(32'h1234_5678)
    };

    // Synchronous reset, released at a falling edge. The unit then clears its
    // valid bits before it takes the first item, but it accepts register writes
    // during that pass.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIRECTED_ROWS; k++) begin
      if (directed_plan[k].is_cfg) begin
        wait_idle();
        write_reg(directed_plan[k].index, directed_plan[k].value[CFG_DATA_W-1:0]);
      end else begin
        send_access(directed_plan[k].value, directed_plan[k].typed,
                    '{directed_plan[k].outcome, directed_plan[k].evicted});
      end
    end

    // Random part. Each phase takes a fresh register setting; the first three
    // cover the extremes, with the upper data bits set on the narrower
    // registers to show they are dropped. Idling runs receiver-heavy for the
    // first three phases, sender-heavy for the next three, then not at all.
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      send_idle_pct  = (phase < 3) ? 37 : ((phase < 6) ? 47 : 0);
      recv_stall_pct = (phase < 3) ? 47 : ((phase < 6) ? 37 : 0);
      case (phase)
        0: begin
          sb = 5'd0;  ob = 5'd0;  wy = 5'd1;  pl = CFG_DATA_W'(POL_LRU);
        end
        1: begin
          sb = 5'd8;  ob = 5'd16; wy = 5'd8;  pl = CFG_DATA_W'(POL_RAND);
        end
        2: begin
          sb = 5'h1F; ob = 5'd31; wy = 5'h1F; pl = 5'h1D;
        end
        default: begin
          sb = CFG_DATA_W'($urandom_range(8));
          ob = CFG_DATA_W'($urandom_range(16));
          wy = CFG_DATA_W'($urandom_range(15));
          pl = CFG_DATA_W'($urandom_range(3));
        end
      endcase
      write_reg(CFG_SET_BITS, sb);
      write_reg(CFG_OFFSET_BITS, ob);
      write_reg(CFG_WAYS_IN_USE, wy);
      write_reg(CFG_POLICY, pl);

      // A small working set of tags and sets per phase keeps sets full, so
      // hits, recency moves and evictions are frequent. One item in five is
      // a fully random address.
      for (k = 0; k < TAG_POOL; k++) tag_pool[k] = $urandom;
      for (k = 0; k < SET_POOL; k++) set_pool[k] = $urandom;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Halfway through, the sender holds back until the unit has drained.
        if (n == PHASE_ITEMS / 2) wait_idle();
        if ($urandom_range(99) < 80) begin
          composed = ({32'd0, tag_pool[$urandom_range(TAG_POOL - 1)]}
                        << (cfg_set_bits + cfg_offset_bits))
                   | (({32'd0, set_pool[$urandom_range(SET_POOL - 1)]}
                        & ((64'd1 << cfg_set_bits) - 64'd1)) << cfg_offset_bits)
                   | ({32'd0, $urandom} & ((64'd1 << cfg_offset_bits) - 64'd1));
          addr = composed[ADDR_W-1:0];
        end else begin
          addr = $urandom;
        end
        send_access(addr, 1'b0, '0);
      end
    end

    // Let the last results arrive, then watch a little longer for strays.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hang: a correct run needs a small fraction of this.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
